// ===== hw/rtl/cci_pkg.sv =====
// Shared widths, status codes and the pipeline item type for the intersection block.
package cci_pkg;

  localparam int COORD_W   = 32;
  localparam int RAD_W     = 31;
  localparam int MAG_W     = 32;
  localparam int SQ_W      = 2 * RAD_W;
  localparam int NUM_W     = 65;
  localparam int ROOT_IN_W = 64;
  localparam int ROOT_W    = 32;
  localparam int DVS_W     = 33;
  localparam int QUO_W     = NUM_W;
  localparam int PROD_W    = RAD_W + MAG_W;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_COINCIDENT = 2'd1;
  localparam logic [1:0] STATUS_NO_CROSS   = 2'd2;

  typedef struct packed {
    logic [1:0]         status;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [RAD_W-1:0]   r0;
    logic [MAG_W-1:0]   adx;
    logic [MAG_W-1:0]   ady;
    logic               dx_neg;
    logic               dy_neg;
    logic               a_neg;
    logic [SQ_W-1:0]    r0sq;
    logic [NUM_W-1:0]   num;
    logic [ROOT_W-1:0]  d;
    logic [RAD_W-1:0]   am;
  } item_t;

endpackage

// ===== hw/rtl/circle_circle_intersection.sv =====
// Top level of the two-circle intersection pipeline.
//
//   Channel  Handshake              Beat contents
//   -------  ---------------------  ----------------------------------------------
//   in       in_valid / in_stall    center0_x, center0_y, radius0,
//                                   center1_x, center1_y, radius1
//   out      out_valid / out_stall  first_x, first_y, second_x, second_y, status
//
// One beat enters per cycle unless the pipeline is stalled; the depth
// comes from the bit-per-stage square-root and divide pipelines.
// Reset (synchronous, active high) clears every stage valid bit; payload
// registers are not reset.
// When out_valid is high and out_stall is asserted the whole pipeline holds,
// and in_stall is raised in the same cycle, so no beat is lost or repeated.
module circle_circle_intersection (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] center0_x,
  input  logic signed [31:0] center0_y,
  input  logic [30:0]        radius0,
  input  logic signed [31:0] center1_x,
  input  logic signed [31:0] center1_y,
  input  logic [30:0]        radius1,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] first_x,
  output logic signed [31:0] first_y,
  output logic signed [31:0] second_x,
  output logic signed [31:0] second_y,
  output logic [1:0]         status
);
  // Single advance enable for every stage: the pipeline moves unless the
  // result register holds a beat that downstream is refusing.
  logic en;

  logic                          fr_vld;
  cci_pkg::item_t                fr_item;
  logic [cci_pkg::ROOT_IN_W-1:0] fr_opnd;
  logic                          sq_vld;
  cci_pkg::item_t                sq_item;
  logic [cci_pkg::ROOT_W-1:0]    sq_root;
  cci_pkg::item_t                sq_item_d;
  logic                          dv_vld;
  cci_pkg::item_t                dv_item;
  logic [cci_pkg::QUO_W-1:0]     dv_quo;
  logic                          ht_vld;
  cci_pkg::item_t                ht_item;
  logic [cci_pkg::RAD_W-1:0]     ht_h;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Offsets, squares, range check and the numerator of the base distance.
  cci_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .vld_in    (in_valid),
    .center0_x (center0_x),
    .center0_y (center0_y),
    .radius0   (radius0),
    .center1_x (center1_x),
    .center1_y (center1_y),
    .radius1   (radius1),
    .vld_out   (fr_vld),
    .item_out  (fr_item),
    .opnd      (fr_opnd)
  );

  // Center distance d = floor(sqrt(D)).
  cci_sqrt u_dist (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (fr_vld),
    .item_in  (fr_item),
    .opnd     (fr_opnd),
    .vld_out  (sq_vld),
    .item_out (sq_item),
    .root     (sq_root)
  );

  always_comb begin
    sq_item_d   = sq_item;
    sq_item_d.d = sq_root;
  end

  // Base distance magnitude |r0^2 - r1^2 + D| / (2d).
  cci_div u_base (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (sq_vld),
    .item_in  (sq_item_d),
    .num      (sq_item.num),
    .dvs      ({sq_root, 1'b0}),
    .vld_out  (dv_vld),
    .item_out (dv_item),
    .quo      (dv_quo)
  );

  // Clamp to r0 and take the height h.
  cci_height u_height (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (dv_vld),
    .item_in  (dv_item),
    .quo      (dv_quo),
    .vld_out  (ht_vld),
    .item_out (ht_item),
    .h        (ht_h)
  );

  // Base point, perpendicular offsets and the saturated output register.
  cci_points u_points (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (ht_vld),
    .item_in  (ht_item),
    .h        (ht_h),
    .vld_out  (out_valid),
    .first_x  (first_x),
    .first_y  (first_y),
    .second_x (second_x),
    .second_y (second_y),
    .status   (status)
  );

endmodule

// ===== hw/rtl/cci_sqrt.sv =====
// Bit-per-stage pipelined floor square root with the item carried alongside.
module cci_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          vld_in,
  input  cci_pkg::item_t                item_in,
  input  logic [cci_pkg::ROOT_IN_W-1:0] opnd,
  output logic                          vld_out,
  output cci_pkg::item_t                item_out,
  output logic [cci_pkg::ROOT_W-1:0]    root
);
  localparam int STAGES = cci_pkg::ROOT_W;
  localparam int REM_W  = cci_pkg::ROOT_W + 3;

  logic                          vld  [STAGES];
  cci_pkg::item_t                item [STAGES];
  logic [REM_W-1:0]              rem  [STAGES];
  logic [cci_pkg::ROOT_W-1:0]    part [STAGES];
  logic [cci_pkg::ROOT_IN_W-1:0] bits [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic                          p_vld;
    cci_pkg::item_t                p_item;
    logic [REM_W-1:0]              p_rem;
    logic [cci_pkg::ROOT_W-1:0]    p_part;
    logic [cci_pkg::ROOT_IN_W-1:0] p_bits;
    logic [REM_W-1:0]              cur;
    logic [REM_W-1:0]              trial;
    logic                          take;

    if (s == 0) begin : g_first
      assign p_vld  = vld_in;
      assign p_item = item_in;
      assign p_rem  = '0;
      assign p_part = '0;
      assign p_bits = opnd;
    end else begin : g_next
      assign p_vld  = vld[s-1];
      assign p_item = item[s-1];
      assign p_rem  = rem[s-1];
      assign p_part = part[s-1];
      assign p_bits = bits[s-1];
    end

    assign cur   = {p_rem[REM_W-3:0], p_bits[cci_pkg::ROOT_IN_W-1 -: 2]};
    assign trial = {1'b0, p_part, 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        item[s] <= p_item;
        bits[s] <= p_bits << 2;
        rem[s]  <= take ? cur - trial : cur;
        part[s] <= {p_part[cci_pkg::ROOT_W-2:0], take};
      end
    end
  end

  assign vld_out  = vld[STAGES-1];
  assign item_out = item[STAGES-1];
  assign root     = part[STAGES-1];

endmodule

// ===== hw/rtl/cci_div.sv =====
// Bit-per-stage pipelined restoring divider with the item carried alongside.
module cci_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      vld_in,
  input  cci_pkg::item_t            item_in,
  input  logic [cci_pkg::NUM_W-1:0] num,
  input  logic [cci_pkg::DVS_W-1:0] dvs,
  output logic                      vld_out,
  output cci_pkg::item_t            item_out,
  output logic [cci_pkg::QUO_W-1:0] quo
);
  localparam int STAGES = cci_pkg::NUM_W;
  localparam int CUR_W  = cci_pkg::DVS_W + 1;

  logic                      vld  [STAGES];
  cci_pkg::item_t            item [STAGES];
  logic [cci_pkg::DVS_W-1:0] rem  [STAGES];
  logic [cci_pkg::DVS_W-1:0] dv   [STAGES];
  logic [cci_pkg::NUM_W-1:0] nsh  [STAGES];
  logic [cci_pkg::QUO_W-1:0] qt   [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic                      p_vld;
    cci_pkg::item_t            p_item;
    logic [cci_pkg::DVS_W-1:0] p_rem;
    logic [cci_pkg::DVS_W-1:0] p_dv;
    logic [cci_pkg::NUM_W-1:0] p_nsh;
    logic [cci_pkg::QUO_W-1:0] p_qt;
    logic [CUR_W-1:0]          cur;
    logic [CUR_W-1:0]          diff;
    logic                      take;

    if (s == 0) begin : g_first
      assign p_vld  = vld_in;
      assign p_item = item_in;
      assign p_rem  = '0;
      assign p_dv   = dvs;
      assign p_nsh  = num;
      assign p_qt   = '0;
    end else begin : g_next
      assign p_vld  = vld[s-1];
      assign p_item = item[s-1];
      assign p_rem  = rem[s-1];
      assign p_dv   = dv[s-1];
      assign p_nsh  = nsh[s-1];
      assign p_qt   = qt[s-1];
    end

    assign cur  = {p_rem, p_nsh[cci_pkg::NUM_W-1]};
    assign diff = cur - {1'b0, p_dv};
    assign take = cur >= {1'b0, p_dv};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        item[s] <= p_item;
        dv[s]   <= p_dv;
        nsh[s]  <= p_nsh << 1;
        rem[s]  <= take ? diff[cci_pkg::DVS_W-1:0] : cur[cci_pkg::DVS_W-1:0];
        qt[s]   <= {p_qt[cci_pkg::QUO_W-2:0], take};
      end
    end
  end

  assign vld_out  = vld[STAGES-1];
  assign item_out = item[STAGES-1];
  assign quo      = qt[STAGES-1];

endmodule

// ===== hw/rtl/cci_front.sv =====
// Front stages: center offset, magnitudes, squares, status and the base numerator.
module cci_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          vld_in,
  input  logic signed [31:0]            center0_x,
  input  logic signed [31:0]            center0_y,
  input  logic [30:0]                   radius0,
  input  logic signed [31:0]            center1_x,
  input  logic signed [31:0]            center1_y,
  input  logic [30:0]                   radius1,
  output logic                          vld_out,
  output cci_pkg::item_t                item_out,
  output logic [cci_pkg::ROOT_IN_W-1:0] opnd
);
  localparam int CW = cci_pkg::COORD_W;
  localparam int RW = cci_pkg::RAD_W;
  localparam int MW = cci_pkg::MAG_W;
  localparam int SW = cci_pkg::SQ_W;
  localparam int NW = cci_pkg::NUM_W;
  localparam int QW = 2 * MW;

  // Stage 1: offsets.
  logic                 s1_vld;
  logic [CW-1:0]        s1_x0, s1_y0;
  logic [RW-1:0]        s1_r0, s1_r1;
  logic signed [CW:0]   s1_dx, s1_dy;
  // Stage 2: magnitudes and radius sum and difference.
  logic                 s2_vld;
  logic [CW-1:0]        s2_x0, s2_y0;
  logic [RW-1:0]        s2_r0, s2_r1, s2_rdiff;
  logic [RW:0]          s2_rsum;
  logic [MW-1:0]        s2_adx, s2_ady;
  logic                 s2_dxn, s2_dyn, s2_coinc;
  // Stage 3: squares.
  logic                 s3_vld;
  logic [CW-1:0]        s3_x0, s3_y0;
  logic [RW-1:0]        s3_r0;
  logic [MW-1:0]        s3_adx, s3_ady;
  logic                 s3_dxn, s3_dyn, s3_coinc;
  logic [QW-1:0]        s3_sqx, s3_sqy, s3_sum_sq;
  logic [SW-1:0]        s3_diff_sq, s3_r0sq, s3_r1sq;
  // Stage 4: squared distance.
  logic                 s4_vld;
  logic [CW-1:0]        s4_x0, s4_y0;
  logic [RW-1:0]        s4_r0;
  logic [MW-1:0]        s4_adx, s4_ady;
  logic                 s4_dxn, s4_dyn, s4_coinc;
  logic [QW:0]          s4_dsq;
  logic [QW-1:0]        s4_sum_sq;
  logic [SW-1:0]        s4_diff_sq, s4_r0sq, s4_r1sq;
  // Stage 5: status and r0^2 + D.
  logic                 s5_vld;
  logic [CW-1:0]        s5_x0, s5_y0;
  logic [RW-1:0]        s5_r0;
  logic [MW-1:0]        s5_adx, s5_ady;
  logic                 s5_dxn, s5_dyn;
  logic [1:0]           s5_status;
  logic [NW-1:0]        s5_top;
  logic [QW-1:0]        s5_dsq;
  logic [SW-1:0]        s5_r0sq, s5_r1sq;
  // Stage 6 outputs.
  logic                 s6_vld;
  cci_pkg::item_t       s6_item;
  logic [QW-1:0]        s6_opnd;

  logic [CW:0]          ndx, ndy;
  logic                 no_cross;
  logic [NW-1:0]        r1sq_ext;
  logic                 a_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= vld_in;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x0 <= center0_x;
      s1_y0 <= center0_y;
      s1_r0 <= radius0;
      s1_r1 <= radius1;
      s1_dx <= $signed({center1_x[CW-1], center1_x}) - $signed({center0_x[CW-1], center0_x});
      s1_dy <= $signed({center1_y[CW-1], center1_y}) - $signed({center0_y[CW-1], center0_y});
    end
  end

  // An offset never reaches 2^32 in magnitude, so the low bits hold it.
  assign ndx = -s1_dx;
  assign ndy = -s1_dy;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x0    <= s1_x0;
      s2_y0    <= s1_y0;
      s2_r0    <= s1_r0;
      s2_r1    <= s1_r1;
      s2_adx   <= s1_dx[CW] ? ndx[MW-1:0] : s1_dx[MW-1:0];
      s2_ady   <= s1_dy[CW] ? ndy[MW-1:0] : s1_dy[MW-1:0];
      s2_dxn   <= s1_dx[CW];
      s2_dyn   <= s1_dy[CW];
      s2_coinc <= (s1_dx == '0) && (s1_dy == '0);
      s2_rsum  <= {1'b0, s1_r0} + {1'b0, s1_r1};
      s2_rdiff <= (s1_r0 > s1_r1) ? s1_r0 - s1_r1 : s1_r1 - s1_r0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_x0      <= s2_x0;
      s3_y0      <= s2_y0;
      s3_r0      <= s2_r0;
      s3_adx     <= s2_adx;
      s3_ady     <= s2_ady;
      s3_dxn     <= s2_dxn;
      s3_dyn     <= s2_dyn;
      s3_coinc   <= s2_coinc;
      s3_sqx     <= QW'(s2_adx) * QW'(s2_adx);
      s3_sqy     <= QW'(s2_ady) * QW'(s2_ady);
      s3_sum_sq  <= QW'(s2_rsum) * QW'(s2_rsum);
      s3_diff_sq <= SW'(s2_rdiff) * SW'(s2_rdiff);
      s3_r0sq    <= SW'(s2_r0) * SW'(s2_r0);
      s3_r1sq    <= SW'(s2_r1) * SW'(s2_r1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_x0      <= s3_x0;
      s4_y0      <= s3_y0;
      s4_r0      <= s3_r0;
      s4_adx     <= s3_adx;
      s4_ady     <= s3_ady;
      s4_dxn     <= s3_dxn;
      s4_dyn     <= s3_dyn;
      s4_coinc   <= s3_coinc;
      s4_dsq     <= {1'b0, s3_sqx} + {1'b0, s3_sqy};
      s4_sum_sq  <= s3_sum_sq;
      s4_diff_sq <= s3_diff_sq;
      s4_r0sq    <= s3_r0sq;
      s4_r1sq    <= s3_r1sq;
    end
  end

  assign no_cross = (s4_dsq > {1'b0, s4_sum_sq}) ||
                    ({{(QW+1-SW){1'b0}}, s4_diff_sq} > s4_dsq);

  // Past the range check D fits 64 bits, so its low word is all that follows.
  always_ff @(posedge clk) begin
    if (en) begin
      s5_x0   <= s4_x0;
      s5_y0   <= s4_y0;
      s5_r0   <= s4_r0;
      s5_adx  <= s4_adx;
      s5_ady  <= s4_ady;
      s5_dxn  <= s4_dxn;
      s5_dyn  <= s4_dyn;
      s5_dsq  <= s4_dsq[QW-1:0];
      s5_r0sq <= s4_r0sq;
      s5_r1sq <= s4_r1sq;
      s5_top  <= NW'(s4_r0sq) + NW'(s4_dsq[QW-1:0]);
      if (s4_coinc) begin
        s5_status <= cci_pkg::STATUS_COINCIDENT;
      end else if (no_cross) begin
        s5_status <= cci_pkg::STATUS_NO_CROSS;
      end else begin
        s5_status <= cci_pkg::STATUS_OK;
      end
    end
  end

  assign r1sq_ext = NW'(s5_r1sq);
  assign a_neg    = r1sq_ext > s5_top;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_opnd        <= s5_dsq;
      s6_item.status <= s5_status;
      s6_item.x0     <= s5_x0;
      s6_item.y0     <= s5_y0;
      s6_item.r0     <= s5_r0;
      s6_item.adx    <= s5_adx;
      s6_item.ady    <= s5_ady;
      s6_item.dx_neg <= s5_dxn;
      s6_item.dy_neg <= s5_dyn;
      s6_item.a_neg  <= a_neg;
      s6_item.r0sq   <= s5_r0sq;
      s6_item.num    <= a_neg ? r1sq_ext - s5_top : s5_top - r1sq_ext;
      s6_item.d      <= '0;
      s6_item.am     <= '0;
    end
  end

  assign vld_out  = s6_vld;
  assign item_out = s6_item;
  assign opnd     = s6_opnd;

endmodule

// ===== hw/rtl/cci_height.sv =====
// Height stages: clamp of the base distance, r0^2 - a^2 and its square root.
module cci_height (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      vld_in,
  input  cci_pkg::item_t            item_in,
  input  logic [cci_pkg::QUO_W-1:0] quo,
  output logic                      vld_out,
  output cci_pkg::item_t            item_out,
  output logic [cci_pkg::RAD_W-1:0] h
);
  localparam int RW = cci_pkg::RAD_W;
  localparam int SW = cci_pkg::SQ_W;

  logic                          h1_vld, h2_vld, h3_vld;
  cci_pkg::item_t                in_am;
  cci_pkg::item_t                h1_item, h2_item, h3_item;
  logic [SW-1:0]                 h2_amsq;
  logic [SW-1:0]                 h3_hop;
  logic [cci_pkg::ROOT_W-1:0]    root;

  // The base distance is clamped to r0 before it is stored with the item.
  always_comb begin
    in_am    = item_in;
    in_am.am = (quo > cci_pkg::QUO_W'(item_in.r0)) ? item_in.r0 : quo[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h1_vld <= 1'b0;
      h2_vld <= 1'b0;
      h3_vld <= 1'b0;
    end else if (en) begin
      h1_vld <= vld_in;
      h2_vld <= h1_vld;
      h3_vld <= h2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1_item    <= in_am;
      h2_item    <= h1_item;
      h2_amsq    <= SW'(h1_item.am) * SW'(h1_item.am);
      h3_item    <= h2_item;
      h3_hop     <= h2_item.r0sq - h2_amsq;
    end
  end

  cci_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (h3_vld),
    .item_in  (h3_item),
    .opnd     ({{(cci_pkg::ROOT_IN_W-SW){1'b0}}, h3_hop}),
    .vld_out  (vld_out),
    .item_out (item_out),
    .root     (root)
  );

  assign h = root[RW-1:0];

endmodule

// ===== hw/rtl/cci_points.sv =====
// Point stages: scaled offsets along the center line, the two points and saturation.
module cci_points (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      vld_in,
  input  cci_pkg::item_t            item_in,
  input  logic [cci_pkg::RAD_W-1:0] h,
  output logic                      vld_out,
  output logic signed [31:0]        first_x,
  output logic signed [31:0]        first_y,
  output logic signed [31:0]        second_x,
  output logic signed [31:0]        second_y,
  output logic [1:0]                status
);
  localparam int PW = cci_pkg::PROD_W;
  localparam int MW = cci_pkg::MAG_W;
  localparam int CW = cci_pkg::COORD_W;
  localparam int TW = CW + 2;
  localparam int FW = CW + 3;
  localparam logic signed [FW-1:0] MAX_POS = FW'(32'sh7fffffff);
  localparam logic signed [FW-1:0] MIN_NEG = -(FW'(33'sh080000000));

  logic                      p1_vld;
  cci_pkg::item_t            p1_item;
  logic [PW-1:0]             p1_ax, p1_ay, p1_hx, p1_hy;
  logic                      dv_vld;
  cci_pkg::item_t            dv_item;
  logic [cci_pkg::QUO_W-1:0] q_ax, q_ay, q_hx, q_hy;
  logic [cci_pkg::DVS_W-1:0] dvs;
  logic                      p2_vld;
  logic [1:0]                p2_status;
  logic signed [TW-1:0]      p2_px, p2_py, p2_hdx, p2_hdy;
  logic signed [TW-1:0]      x0_ext, y0_ext, t_ax, t_ay, t_hx, t_hy;

  function automatic logic [31:0] sat32(input logic signed [FW-1:0] v);
    logic [31:0] r;
    if (v > MAX_POS) begin
      r = 32'h7fffffff;
    end else if (v < MIN_NEG) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld  <= 1'b0;
      p2_vld  <= 1'b0;
      vld_out <= 1'b0;
    end else if (en) begin
      p1_vld  <= vld_in;
      p2_vld  <= dv_vld;
      vld_out <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_item <= item_in;
      p1_ax   <= PW'(item_in.am) * PW'(item_in.adx);
      p1_ay   <= PW'(item_in.am) * PW'(item_in.ady);
      p1_hx   <= PW'(h) * PW'(item_in.adx);
      p1_hy   <= PW'(h) * PW'(item_in.ady);
    end
  end

  assign dvs = cci_pkg::DVS_W'(p1_item.d);

  cci_div u_div_ax (
    .clk (clk), .rst (rst), .en (en), .vld_in (p1_vld), .item_in (p1_item),
    .num (cci_pkg::NUM_W'(p1_ax)), .dvs (dvs),
    .vld_out (dv_vld), .item_out (dv_item), .quo (q_ax)
  );

  cci_div u_div_ay (
    .clk (clk), .rst (rst), .en (en), .vld_in (p1_vld), .item_in (p1_item),
    .num (cci_pkg::NUM_W'(p1_ay)), .dvs (dvs),
    .vld_out (), .item_out (), .quo (q_ay)
  );

  cci_div u_div_hx (
    .clk (clk), .rst (rst), .en (en), .vld_in (p1_vld), .item_in (p1_item),
    .num (cci_pkg::NUM_W'(p1_hx)), .dvs (dvs),
    .vld_out (), .item_out (), .quo (q_hx)
  );

  cci_div u_div_hy (
    .clk (clk), .rst (rst), .en (en), .vld_in (p1_vld), .item_in (p1_item),
    .num (cci_pkg::NUM_W'(p1_hy)), .dvs (dvs),
    .vld_out (), .item_out (), .quo (q_hy)
  );

  // Each quotient is bounded by am or h, so it fits well inside the low word.
  assign x0_ext = $signed({{2{dv_item.x0[CW-1]}}, dv_item.x0});
  assign y0_ext = $signed({{2{dv_item.y0[CW-1]}}, dv_item.y0});
  assign t_ax   = $signed({2'b00, q_ax[MW-1:0]});
  assign t_ay   = $signed({2'b00, q_ay[MW-1:0]});
  assign t_hx   = $signed({2'b00, q_hx[MW-1:0]});
  assign t_hy   = $signed({2'b00, q_hy[MW-1:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      p2_status <= dv_item.status;
      p2_px     <= (dv_item.a_neg ^ dv_item.dx_neg) ? x0_ext - t_ax : x0_ext + t_ax;
      p2_py     <= (dv_item.a_neg ^ dv_item.dy_neg) ? y0_ext - t_ay : y0_ext + t_ay;
      p2_hdx    <= dv_item.dx_neg ? -t_hx : t_hx;
      p2_hdy    <= dv_item.dy_neg ? -t_hy : t_hy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status <= p2_status;
      if (p2_status == cci_pkg::STATUS_OK) begin
        first_x  <= sat32(FW'(p2_px) + FW'(p2_hdy));
        first_y  <= sat32(FW'(p2_py) - FW'(p2_hdx));
        second_x <= sat32(FW'(p2_px) - FW'(p2_hdy));
        second_y <= sat32(FW'(p2_py) + FW'(p2_hdx));
      end else begin
        first_x  <= '0;
        first_y  <= '0;
        second_x <= '0;
        second_y <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/cci_checker.sv =====
// Port-level checker for the intersection block, bound to the top level.
module cci_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [31:0] center0_x,
  input logic signed [31:0] center0_y,
  input logic [30:0]        radius0,
  input logic signed [31:0] center1_x,
  input logic signed [31:0] center1_y,
  input logic [30:0]        radius1,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] first_x,
  input logic signed [31:0] first_y,
  input logic signed [31:0] second_x,
  input logic signed [31:0] second_y,
  input logic [1:0]         status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(first_x) && $stable(first_y) &&
      $stable(second_x) && $stable(second_y) && $stable(status))
    else $error("result beat changed while stalled");

  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the output register");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != cci_pkg::STATUS_OK) |->
      first_x == 0 && first_y == 0 && second_x == 0 && second_y == 0)
    else $error("failed query carries nonzero points");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat present right after reset");

endmodule

bind circle_circle_intersection cci_checker u_checker (.*);
